// File: sv/hstp_pkg.sv
// hstp_pkg: shared types and constants for the size text parser
// channel payload structs, the token passed from classifier to scaler
// no dependencies
`default_nettype none

package hstp_pkg;

  // defaults for the top-level parameters
  localparam int MAX_CHARS_DEF       = 20;
  localparam int MAX_FRAC_DIGITS_DEF = 9;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // fixed widths
  localparam int MANT_W = 64;  // mantissa and byte count
  localparam int DIV_W  = 50;  // holds 10^15, the largest divisor
  localparam int STEP_W = 8;   // divide steps, up to 64 + 80
  localparam int FRAC_W = 4;   // fraction digit count
  localparam int POW_W  = 4;   // power of 1024
  localparam int KEEP_W = 5;   // kept character count

  // input transfer
  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } char_item_t;

  // output transfer
  typedef struct packed {
    logic [MANT_W-1:0] size_bytes;
    logic              saturated;
    logic [POW_W-1:0]  unit_power;
  } size_item_t;

  // classified character, front to back
  typedef struct packed {
    logic             take;      // character is kept and parsed
    logic             last;      // end of string
    logic             is_digit;
    logic             is_space;
    logic             is_plus;
    logic             is_minus;
    logic             is_dot;
    logic [3:0]       digit;
    logic             unit_hit;
    logic [POW_W-1:0] unit_pow;
  } token_t;

endpackage

`default_nettype wire

// File: sv/hstp_front.sv
// hstp_front: takes text bytes, drops escapes, limits the kept count
// and classifies each kept character into a token; uses hstp_pkg
`default_nettype none

module hstp_front #(
  parameter int MAX_CHARS = hstp_pkg::MAX_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  hstp_pkg::char_item_t char_data,
  output logic                push,
  output hstp_pkg::token_t    push_token,
  input  logic                full
);

  localparam int KW = hstp_pkg::KEEP_W;
  localparam int PW = hstp_pkg::POW_W;
  localparam logic [KW-1:0] KEEP_MAX = KW'(MAX_CHARS);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // unit letter lookup on an upper-case character: {hit, power}
  function automatic logic [PW:0] unit_lookup(input logic [7:0] up);
    logic [PW:0] res;
    case (up)
      "B":     res = {1'b1, PW'(0)};
      "K":     res = {1'b1, PW'(1)};
      "M":     res = {1'b1, PW'(2)};
      "G":     res = {1'b1, PW'(3)};
      "T":     res = {1'b1, PW'(4)};
      "P":     res = {1'b1, PW'(5)};
      "E":     res = {1'b1, PW'(6)};
      "Z":     res = {1'b1, PW'(7)};
      "Y":     res = {1'b1, PW'(8)};
      default: res = '0;
    endcase
    return res;
  endfunction

  logic          in_escape;
  logic [KW-1:0] kept_count;
  logic [7:0]    c;
  logic [7:0]    upper;
  logic [PW:0]   unit;
  logic          accept;
  logic          is_nul;
  logic          esc_now;
  logic          keep;

  // classify the current byte
  assign c       = char_data.text_byte;
  assign accept  = char_valid && !full;
  assign is_nul  = (c == CH_NUL);
  assign esc_now = in_escape || (c == CH_AMP);
  assign keep    = !is_nul && !esc_now && (kept_count < KEEP_MAX);
  assign upper   = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_GAP : c;
  assign unit    = unit_lookup(upper);

  assign push       = accept && (keep || char_data.last_byte);
  assign char_stall = full;

  always_comb begin
    push_token.take     = keep;
    push_token.last     = char_data.last_byte;
    push_token.is_digit = (c >= CH_ZERO && c <= CH_NINE);
    push_token.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    push_token.is_plus  = (c == CH_PLUS);
    push_token.is_minus = (c == CH_MINUS);
    push_token.is_dot   = (c == CH_DOT);
    push_token.digit    = c[3:0];
    push_token.unit_hit = unit[PW];
    push_token.unit_pow = unit[PW-1:0];
  end

  // escape tracking and kept count, cleared at end of string
  always_ff @(posedge clk) begin
    if (rst) begin
      in_escape  <= 1'b0;
      kept_count <= '0;
    end else if (accept) begin
      if (char_data.last_byte) begin
        in_escape  <= 1'b0;
        kept_count <= '0;
      end else if (is_nul) begin
        kept_count <= KEEP_MAX;
      end else begin
        if (keep) begin
          kept_count <= kept_count + 1'b1;
        end
        in_escape <= (c == CH_SEMI) ? 1'b0 : esc_now;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/hstp_queue.sv
// hstp_queue: short token queue between classifier and scaler
// register based ring buffer; uses hstp_pkg
`default_nettype none

module hstp_queue #(
  parameter int DEPTH = hstp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hstp_pkg::token_t push_token,
  output logic             full,
  input  logic             pop,
  output hstp_pkg::token_t pop_token,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  hstp_pkg::token_t entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_token = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/hstp_back.sv
// hstp_back: number parser and bit-serial scaler
// accumulates the mantissa per token, then divides mantissa * 1024^p
// by 10^fraction one quotient bit per cycle; uses hstp_pkg
`default_nettype none

module hstp_back #(
  parameter int MAX_FRACTION_DIGITS = hstp_pkg::MAX_FRAC_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 empty,
  output logic                 pop,
  input  hstp_pkg::token_t     pop_token,
  output logic                 size_valid,
  input  logic                 size_stall,
  output hstp_pkg::size_item_t size_data
);

  localparam int MW = hstp_pkg::MANT_W;
  localparam int DW = hstp_pkg::DIV_W;
  localparam int SW = hstp_pkg::STEP_W;
  localparam int FW = hstp_pkg::FRAC_W;
  localparam int PW = hstp_pkg::POW_W;
  localparam logic [FW-1:0] FRAC_LIM = FW'(MAX_FRACTION_DIGITS);

  typedef enum logic [2:0] {
    PH_BEFORE, PH_SIGN, PH_INT, PH_FRAC, PH_END
  } phase_t;

  typedef enum logic [1:0] {
    S_PARSE, S_DIVIDE, S_DONE
  } state_t;

  // powers of ten for the fraction digit count
  function automatic logic [DW-1:0] pow10(input logic [FW-1:0] n);
    logic [DW-1:0] v;
    case (n)
      4'd0:    v = DW'(64'd1);
      4'd1:    v = DW'(64'd10);
      4'd2:    v = DW'(64'd100);
      4'd3:    v = DW'(64'd1000);
      4'd4:    v = DW'(64'd10000);
      4'd5:    v = DW'(64'd100000);
      4'd6:    v = DW'(64'd1000000);
      4'd7:    v = DW'(64'd10000000);
      4'd8:    v = DW'(64'd100000000);
      4'd9:    v = DW'(64'd1000000000);
      4'd10:   v = DW'(64'd10000000000);
      4'd11:   v = DW'(64'd100000000000);
      4'd12:   v = DW'(64'd1000000000000);
      4'd13:   v = DW'(64'd10000000000000);
      4'd14:   v = DW'(64'd100000000000000);
      default: v = DW'(64'd1000000000000000);
    endcase
    return v;
  endfunction

  state_t        state;
  phase_t        phase;
  logic          neg;
  logic [MW-1:0] mant;
  logic          movf;
  logic [FW-1:0] fd;
  logic          unit_found;
  logic [PW-1:0] power;

  phase_t        phase_next;
  logic          neg_next;
  logic [MW-1:0] mant_next;
  logic          movf_next;
  logic [FW-1:0] fd_next;
  logic          unit_found_next;
  logic [PW-1:0] power_next;

  // job registers of the scaler
  logic          j_neg;
  logic          j_movf;
  logic [PW-1:0] j_unit;
  logic [DW-1:0] divisor;
  logic [MW-1:0] num;
  logic [DW-1:0] rem;
  logic [MW-1:0] quot;
  logic          q_ovf;
  logic [SW-1:0] steps;

  logic [MW+3:0] prod;
  logic          wrap;
  logic          start;
  logic          int_acc;
  logic [PW-1:0] job_pow;
  logic [SW-1:0] steps_init;
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW:0]   rem_diff;
  hstp_pkg::token_t t;

  assign t   = pop_token;
  assign pop = (state == S_PARSE) && !empty;

  // times ten plus digit, with carry-out check
  assign prod = ({4'b0, mant} << 3) + ({4'b0, mant} << 1) + {{MW{1'b0}}, t.digit};
  assign wrap = |prod[MW+3:MW];

  // next parse state for one token
  always_comb begin
    phase_next      = phase;
    neg_next        = neg;
    mant_next       = mant;
    movf_next       = movf;
    fd_next         = fd;
    unit_found_next = unit_found;
    power_next      = power;
    start           = 1'b0;
    int_acc         = 1'b0;
    if (t.take) begin
      if (!unit_found && t.unit_hit) begin
        unit_found_next = 1'b1;
        power_next      = t.unit_pow;
      end
      case (phase)
        PH_BEFORE: begin
          if (!t.is_space) begin
            if (t.is_plus || t.is_minus) begin
              neg_next   = t.is_minus;
              phase_next = PH_SIGN;
            end else begin
              start = 1'b1;
            end
          end
        end
        PH_SIGN: start = 1'b1;
        PH_INT: begin
          if (t.is_dot) begin
            phase_next = PH_FRAC;
          end else if (!t.is_digit) begin
            phase_next = PH_END;
          end else begin
            int_acc = 1'b1;
          end
        end
        PH_FRAC: begin
          if (!t.is_digit) begin
            phase_next = PH_END;
          end else if (!movf && fd < FRAC_LIM && !wrap) begin
            mant_next = prod[MW-1:0];
            fd_next   = fd + 1'b1;
          end
        end
        default: ;
      endcase
      // first character of the number proper
      if (start) begin
        if (t.is_dot) begin
          phase_next = PH_FRAC;
        end else if (!t.is_digit) begin
          phase_next = PH_END;
        end else begin
          phase_next = PH_INT;
          int_acc    = 1'b1;
        end
      end
      // integer digit
      if (int_acc && !movf) begin
        if (wrap) begin
          movf_next = 1'b1;
        end else begin
          mant_next = prod[MW-1:0];
        end
      end
    end
  end

  // divide length: all mantissa bits plus ten per power of 1024
  assign job_pow    = unit_found_next ? power_next : '0;
  assign steps_init = SW'(MW) + ({{(SW-PW){1'b0}}, job_pow} << 3)
                              + ({{(SW-PW){1'b0}}, job_pow} << 1);

  // one restoring divide step
  assign rem_sh   = {rem, num[MW-1]};
  assign ge       = (rem_sh >= {1'b0, divisor});
  assign rem_diff = rem_sh - {1'b0, divisor};

  // parse, divide and hand-over sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_PARSE;
      phase      <= PH_BEFORE;
      neg        <= 1'b0;
      mant       <= '0;
      movf       <= 1'b0;
      fd         <= '0;
      unit_found <= 1'b0;
      power      <= '0;
      size_valid <= 1'b0;
    end else begin
      if (size_valid && !size_stall && state != S_DONE) begin
        size_valid <= 1'b0;
      end
      case (state)
        S_PARSE: begin
          if (pop) begin
            if (t.last) begin
              j_neg      <= neg_next;
              j_movf     <= movf_next;
              j_unit     <= job_pow;
              divisor    <= pow10(fd_next);
              num        <= mant_next;
              rem        <= '0;
              quot       <= '0;
              q_ovf      <= 1'b0;
              steps      <= steps_init;
              phase      <= PH_BEFORE;
              neg        <= 1'b0;
              mant       <= '0;
              movf       <= 1'b0;
              fd         <= '0;
              unit_found <= 1'b0;
              power      <= '0;
              state      <= S_DIVIDE;
            end else begin
              phase      <= phase_next;
              neg        <= neg_next;
              mant       <= mant_next;
              movf       <= movf_next;
              fd         <= fd_next;
              unit_found <= unit_found_next;
              power      <= power_next;
            end
          end
        end
        S_DIVIDE: begin
          num   <= num << 1;
          rem   <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
          quot  <= {quot[MW-2:0], ge};
          q_ovf <= q_ovf || quot[MW-1];
          steps <= steps - 1'b1;
          if (steps == SW'(1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!size_valid || !size_stall) begin
            size_valid           <= 1'b1;
            size_data.unit_power <= j_unit;
            if (j_neg) begin
              size_data.size_bytes <= '0;
              size_data.saturated  <= 1'b0;
            end else if (j_movf || q_ovf) begin
              size_data.size_bytes <= '1;
              size_data.saturated  <= 1'b1;
            end else begin
              size_data.size_bytes <= quot;
              size_data.saturated  <= 1'b0;
            end
            state <= S_PARSE;
          end
        end
        default: state <= S_PARSE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/human_size_text_parser_core.sv
// human_size_text_parser_core: size text to byte count, top level
// joins hstp_front, hstp_queue and hstp_back; uses hstp_pkg
//
//   channel   | valid       | stall       | payload
//   ----------+-------------+-------------+---------------------------
//   text in   | char_valid  | char_stall  | char_data  (char_item_t)
//   size out  | size_valid  | size_stall  | size_data  (size_item_t)
//
// the classifier takes one byte per cycle while the token queue has room
// the parser retires one queued token per cycle, but none while dividing or handing over
// the last token loads the job registers, then the serial divider runs one
// step per mantissa bit, ten per unit power, then loads the output register
// rst is synchronous and empties the queue and clears all parse state
// char_stall follows queue full; size_stall holds the output register and
// the divider result waits until the register frees
`default_nettype none

module human_size_text_parser_core #(
  parameter int MAX_CHARS           = hstp_pkg::MAX_CHARS_DEF,
  parameter int MAX_FRACTION_DIGITS = hstp_pkg::MAX_FRAC_DIGITS_DEF,
  parameter int QUEUE_DEPTH         = hstp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  hstp_pkg::char_item_t char_data,
  output logic                 size_valid,
  input  logic                 size_stall,
  output hstp_pkg::size_item_t size_data
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  hstp_pkg::token_t push_token;
  hstp_pkg::token_t pop_token;

  // byte classifier
  hstp_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .push       (push),
    .push_token (push_token),
    .full       (full)
  );

  // token queue
  hstp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (full),
    .pop        (pop),
    .pop_token  (pop_token),
    .empty      (empty)
  );

  // number parser and scaler
  hstp_back #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .pop        (pop),
    .pop_token  (pop_token),
    .size_valid (size_valid),
    .size_stall (size_stall),
    .size_data  (size_data)
  );

endmodule

`default_nettype wire

// File: sv/hstp_checker.sv
// hstp_checker: port-level checks for human_size_text_parser_core
// bound to the top level; uses hstp_pkg
`default_nettype none

module hstp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 char_stall,
  input logic                 size_valid,
  input logic                 size_stall,
  input hstp_pkg::size_item_t size_data
);

  // reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !size_valid)
    else $error("result valid right after reset");

  // reset leaves the token queue empty, so input is open
  a_reset_in: assert property (@(posedge clk) $past(rst) |-> !char_stall)
    else $error("input stalled right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    size_valid && size_stall |=> size_valid && $stable(size_data))
    else $error("stalled result changed");

  // saturation always shows the full-scale count
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    size_valid && size_data.saturated |-> size_data.size_bytes == {64{1'b1}})
    else $error("saturated result not at maximum");

  // unit power stays within the letter set
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    size_valid |-> size_data.unit_power <= 4'd8)
    else $error("unit power out of range");

endmodule

bind human_size_text_parser_core hstp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .char_stall (char_stall),
  .size_valid (size_valid),
  .size_stall (size_stall),
  .size_data  (size_data)
);

`default_nettype wire
